// ===== rtl/first_fit_job_scheduler_assert.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef FIRST_FIT_JOB_SCHEDULER_ASSERT_SVH
`define FIRST_FIT_JOB_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FFJS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler port check failed");

// Next-cycle implication.
`define FFJS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler port check failed");

`endif

// ===== rtl/ffjs_pkg.sv =====
`timescale 1ns / 1ps
package ffjs_pkg;

   localparam int WORKER_COUNT     = 8;
   localparam int PENDING_DEPTH    = 64;
   localparam int SLOTS_PER_WORKER = 16;
   localparam int FULL_CAP         = 100;

   localparam int WRK_IDX_W  = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;
   localparam int PEND_IDX_W = $clog2(PENDING_DEPTH);
   localparam int PEND_CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int SLOT_IDX_W = (SLOTS_PER_WORKER > 1) ? $clog2(SLOTS_PER_WORKER) : 1;
   localparam int BUSY_CNT_W = $clog2(WORKER_COUNT + 1);
   localparam int WEIGHT_W   = 33;

   typedef enum logic [2:0] {
      STAT_ACCEPTED = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_CPU_OVER = 3'd2,
      STAT_TICKED   = 3'd3,
      STAT_ALL_DONE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      MODE_ARRIVAL  = 3'd0,
      MODE_CPU      = 3'd1,
      MODE_TIME     = 3'd2,
      MODE_CPU_TIME = 3'd3,
      MODE_TIME_CPU = 3'd4,
      MODE_WEIGHTED = 3'd5
   } sort_mode_type;

   typedef enum logic [1:0] {
      CSR_SORT_MODE = 2'd0,
      CSR_THETA     = 2'd1,
      CSR_WORKERS   = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_ADD  = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_PREP,
      S_INS_PASS,
      S_TICK_PASS,
      S_AGE_PASS,
      S_RESP
   } fsm_type;

   typedef struct packed {
      logic        func;
      logic [15:0] job_id;
      logic [6:0]  job_cpu;
      logic [15:0] job_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  pending_count;
      logic [3:0]  busy_workers;
      logic [6:0]  assigned_now;
      logic [7:0]  completed_now;
      logic [31:0] elapsed_ticks;
      logic [39:0] total_work;
      logic        all_done;
   } rsp_type;

   typedef struct packed {
      logic [15:0] job_id;
      logic [6:0]  job_cpu;
      logic [15:0] job_time;
   } pend_type;

   typedef struct packed {
      logic        valid;
      logic [6:0]  cpu;
      logic [15:0] left;
   } slot_type;

   // cpu in Q8.8 plus theta times time
   function automatic logic [WEIGHT_W-1:0] weight_of(logic [6:0] cpu, logic [15:0] t,
                                                     logic [15:0] th);
      logic [31:0] prod;
      prod = {16'b0, th} * {16'b0, t};
      return WEIGHT_W'(prod) + WEIGHT_W'({cpu, 8'h00});
   endfunction

   // a strictly ahead of b in the given mode, ties to the lower id
   function automatic logic job_precedes(logic [2:0] mode, pend_type a, pend_type b,
                                         logic [WEIGHT_W-1:0] wa,
                                         logic [WEIGHT_W-1:0] wb);
      logic gt;
      logic lt;
      logic arr;
      gt  = 1'b0;
      lt  = 1'b0;
      arr = 1'b0;
      case (mode)
         MODE_ARRIVAL: begin
            arr = 1'b1;
         end
         MODE_CPU: begin
            gt = a.job_cpu > b.job_cpu;
            lt = a.job_cpu < b.job_cpu;
         end
         MODE_CPU_TIME: begin
            gt = (a.job_cpu > b.job_cpu) ||
                 ((a.job_cpu == b.job_cpu) && (a.job_time > b.job_time));
            lt = (a.job_cpu < b.job_cpu) ||
                 ((a.job_cpu == b.job_cpu) && (a.job_time < b.job_time));
         end
         MODE_TIME_CPU: begin
            gt = (a.job_time > b.job_time) ||
                 ((a.job_time == b.job_time) && (a.job_cpu > b.job_cpu));
            lt = (a.job_time < b.job_time) ||
                 ((a.job_time == b.job_time) && (a.job_cpu < b.job_cpu));
         end
         MODE_WEIGHTED: begin
            gt = wa > wb;
            lt = wa < wb;
         end
         default: begin
            gt = a.job_time > b.job_time;
            lt = a.job_time < b.job_time;
         end
      endcase
      return !arr && (gt || (!lt && (a.job_id < b.job_id)));
   endfunction

endpackage

// ===== rtl/ffjs_pend_cell.sv =====
`timescale 1ns / 1ps
module ffjs_pend_cell (
   input  logic              clock,
   input  logic              shift,
   input  logic              load,
   input  ffjs_pkg::pend_type load_data,
   input  ffjs_pkg::pend_type nbr,
   output ffjs_pkg::pend_type q
);
   import ffjs_pkg::*;

   pend_type entry_ff;
   pend_type entry_in;

   // a load wins over the shift from the upper neighbor
   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = load_data;
      end else if (shift) begin
         entry_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;
endmodule

// ===== rtl/ffjs_slot_cell.sv =====
`timescale 1ns / 1ps
module ffjs_slot_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              rotate,
   input  logic              load,
   input  ffjs_pkg::slot_type load_data,
   input  ffjs_pkg::slot_type nbr,
   output ffjs_pkg::slot_type q
);
   import ffjs_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (load) begin
         slot_in = load_data;
      end else if (rotate) begin
         slot_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.cpu  <= slot_in.cpu;
      slot_ff.left <= slot_in.left;
   end

   assign q = slot_ff;
endmodule

// ===== rtl/first_fit_job_scheduler.sv =====
`timescale 1ns / 1ps
// First-fit job scheduler.
// Requests enter on req_data when start is high and busy is low; func selects
// an add (insert a job into the ordered pending chain) or a one-second tick.
// Every request yields one response: rsp_valid pulses for one cycle with
// rsp_data, and the receiver has no way to hold it off.
// Pending jobs live in a chain of cells that shifts toward cell 0; each pass
// pops the head, examines it and writes it (or the new job) back behind the
// packed tail. Each worker keeps a ring of slot cells that rotates once per
// tick, aging the head slot as it goes around.
// Steps from accept to rsp_valid, with N pending jobs:
//   rejected add or idle tick: straight to the response
//   accepted add: the weights, then a compare against each of the N jobs, then the write
//   tick: a placement pass over the N jobs, then an aging pass over the slots
// One request is handled at a time; busy stays high until the response cycle.
// The configuration port (csr_we, csr_idx, csr_wdata) takes a write per cycle
// and should only be used while busy is low.
// Synchronous reset empties the pending chain, frees all slots, sets every
// worker to full capacity and restores sort_mode 2, theta 256, 8 workers.
module first_fit_job_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffjs_pkg::req_type req_data,
   output logic              rsp_valid,
   output ffjs_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_idx,
   input  logic [15:0]       csr_wdata
);
   import ffjs_pkg::*;

   fsm_type                 state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [2:0]              sort_mode_ff;
   logic [15:0]             theta_ff;
   logic [3:0]              wiu_ff;
   logic [PEND_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PEND_CNT_W-1:0]   tot_ff, tot_in;
   logic [PEND_CNT_W-1:0]   r_ff, r_in;
   logic                    ins_ff, ins_in;
   pend_type                carry_ff, carry_in;
   logic [WEIGHT_W-1:0]     wnew_ff, wnew_in;
   logic [WEIGHT_W-1:0]     whead_ff, whead_in;
   logic [6:0]              cap_ff [WORKER_COUNT];
   logic [6:0]              cap_in [WORKER_COUNT];
   logic [31:0]             tick_ff, tick_in;
   logic [39:0]             work_ff, work_in;
   logic [6:0]              assigned_ff, assigned_in;
   logic [7:0]              completed_ff, completed_in;
   logic [SLOT_IDX_W-1:0]   age_ff, age_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   pend_type                pend_q [PENDING_DEPTH];
   logic                    pend_shift;
   logic                    pend_load;
   logic [PEND_IDX_W-1:0]   load_idx;
   pend_type                pend_wdata;

   slot_type                slot_q [WORKER_COUNT][SLOTS_PER_WORKER];
   slot_type                slot_aged [WORKER_COUNT];
   logic                    slot_done [WORKER_COUNT];
   logic [SLOTS_PER_WORKER-1:0] vbits [WORKER_COUNT];
   logic [SLOT_IDX_W-1:0]   free_idx [WORKER_COUNT];
   logic [SLOT_IDX_W-1:0]   free_sel;
   logic                    slot_rotate;
   logic                    slot_load_en;
   slot_type                slot_wdata;

   pend_type                head;
   pend_type                new_job;
   pend_type                whead_src;
   logic [WEIGHT_W-1:0]     whead_calc;
   logic [WEIGHT_W-1:0]     wnew_calc;
   logic                    prec;
   logic [7:0]              lim;
   logic                    place_ok;
   logic [WRK_IDX_W-1:0]    place_w;
   logic [BUSY_CNT_W-1:0]   busy_cnt;
   logic [7:0]              done_cnt;
   logic [PEND_IDX_W-1:0]   tail_idx;
   logic [PEND_IDX_W-1:0]   end_idx;
   logic [40:0]             work_sum;

   // pending chain
   for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_pend
      pend_type nbr;
      if (i == PENDING_DEPTH - 1) begin : g_last
         assign nbr = pend_q[i];
      end else begin : g_mid
         assign nbr = pend_q[i + 1];
      end
      ffjs_pend_cell u_cell (
         .clock     (clock),
         .shift     (pend_shift),
         .load      (pend_load && (load_idx == PEND_IDX_W'(i))),
         .load_data (pend_wdata),
         .nbr       (nbr),
         .q         (pend_q[i])
      );
   end

   // slot rings, one per worker
   for (genvar w = 0; w < WORKER_COUNT; w++) begin : g_wrk
      for (genvar s = 0; s < SLOTS_PER_WORKER; s++) begin : g_slot
         slot_type nbr;
         if (s == SLOTS_PER_WORKER - 1) begin : g_tail
            assign nbr = slot_aged[w];
         end else begin : g_body
            assign nbr = slot_q[w][s + 1];
         end
         assign vbits[w][s] = slot_q[w][s].valid;
         ffjs_slot_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .rotate    (slot_rotate),
            .load      (slot_load_en && (place_w == WRK_IDX_W'(w)) &&
                        (free_sel == SLOT_IDX_W'(s))),
            .load_data (slot_wdata),
            .nbr       (nbr),
            .q         (slot_q[w][s])
         );
      end
   end

   assign head      = pend_q[0];
   assign new_job   = '{job_id: req_ff.job_id, job_cpu: req_ff.job_cpu,
                        job_time: req_ff.job_time};
   assign whead_src = (state_ff == S_INS_PREP) ? pend_q[0] : pend_q[1];
   assign whead_calc = weight_of(whead_src.job_cpu, whead_src.job_time, theta_ff);
   assign wnew_calc  = weight_of(new_job.job_cpu, new_job.job_time, theta_ff);
   assign prec       = job_precedes(sort_mode_ff, new_job, head, wnew_ff, whead_ff);
   assign tail_idx   = PEND_IDX_W'(cnt_ff - 1'b1);
   assign end_idx    = PEND_IDX_W'(cnt_ff);
   assign work_sum   = {1'b0, work_ff} +
                       41'({16'b0, req_ff.job_cpu} * {7'b0, req_ff.job_time});
   assign slot_wdata = '{valid: 1'b1, cpu: head.job_cpu, left: head.job_time};
   assign free_sel   = free_idx[place_w];

   assign lim = (wiu_ff == 4'd0) ? 8'd1 :
                (({4'b0, wiu_ff}) > 8'(WORKER_COUNT)) ? 8'(WORKER_COUNT) : {4'b0, wiu_ff};

   // lowest free slot of each worker
   always_comb begin
      for (int w = 0; w < WORKER_COUNT; w++) begin
         free_idx[w] = '0;
         for (int s = SLOTS_PER_WORKER - 1; s >= 0; s--) begin
            if (!vbits[w][s]) begin
               free_idx[w] = SLOT_IDX_W'(s);
            end
         end
      end
   end

   // first fit over the workers taking part
   always_comb begin
      place_ok = 1'b0;
      place_w  = '0;
      for (int w = WORKER_COUNT - 1; w >= 0; w--) begin
         if ((8'(w) < lim) && (cap_ff[w] >= head.job_cpu) && !(&vbits[w])) begin
            place_ok = 1'b1;
            place_w  = WRK_IDX_W'(w);
         end
      end
   end

   // age each ring head; drop the slot when its time runs out
   always_comb begin
      done_cnt = '0;
      for (int w = 0; w < WORKER_COUNT; w++) begin
         slot_aged[w] = slot_q[w][0];
         slot_done[w] = slot_q[w][0].valid && (slot_q[w][0].left <= 16'd1);
         if (slot_done[w]) begin
            slot_aged[w].valid = 1'b0;
            done_cnt = done_cnt + 8'd1;
         end else if (slot_q[w][0].valid) begin
            slot_aged[w].left = slot_q[w][0].left - 16'd1;
         end
      end
   end

   always_comb begin
      busy_cnt = '0;
      for (int w = 0; w < WORKER_COUNT; w++) begin
         if (cap_ff[w] < 7'(FULL_CAP)) begin
            busy_cnt = busy_cnt + 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      tot_in       = tot_ff;
      r_in         = r_ff;
      ins_in       = ins_ff;
      carry_in     = carry_ff;
      wnew_in      = wnew_ff;
      whead_in     = whead_ff;
      tick_in      = tick_ff;
      work_in      = work_ff;
      assigned_in  = assigned_ff;
      completed_in = completed_ff;
      age_in       = age_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pend_shift   = 1'b0;
      pend_load    = 1'b0;
      load_idx     = tail_idx;
      pend_wdata   = head;
      slot_rotate  = 1'b0;
      slot_load_en = 1'b0;
      for (int w = 0; w < WORKER_COUNT; w++) begin
         cap_in[w] = cap_ff[w];
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in       = req_data;
               assigned_in  = '0;
               completed_in = '0;
               if (req_data.func == FUNC_ADD) begin
                  if (req_data.job_cpu > 7'(FULL_CAP)) begin
                     status_in = STAT_CPU_OVER;
                     state_in  = S_RESP;
                  end else if (cnt_ff == PEND_CNT_W'(PENDING_DEPTH)) begin
                     status_in = STAT_FULL;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_INS_PREP;
                  end
               end else if ((cnt_ff == '0) && (busy_cnt == '0)) begin
                  status_in = STAT_ALL_DONE;
                  state_in  = S_RESP;
               end else begin
                  r_in     = '0;
                  tot_in   = cnt_ff;
                  state_in = S_TICK_PASS;
               end
            end
         end
         S_INS_PREP: begin
            wnew_in  = wnew_calc;
            whead_in = whead_calc;
            r_in     = '0;
            ins_in   = 1'b0;
            work_in  = work_sum[40] ? '1 : work_sum[39:0];
            state_in = S_INS_PASS;
         end
         S_INS_PASS: begin
            if (r_ff < cnt_ff) begin
               // pop the head, write one entry back behind the tail
               pend_shift = 1'b1;
               pend_load  = 1'b1;
               load_idx   = tail_idx;
               whead_in   = whead_calc;
               r_in       = r_ff + 1'b1;
               if (ins_ff) begin
                  pend_wdata = carry_ff;
                  carry_in   = head;
               end else if (prec) begin
                  pend_wdata = new_job;
                  carry_in   = head;
                  ins_in     = 1'b1;
               end
            end else begin
               pend_load  = 1'b1;
               load_idx   = end_idx;
               pend_wdata = ins_ff ? carry_ff : new_job;
               cnt_in     = cnt_ff + 1'b1;
               status_in  = STAT_ACCEPTED;
               state_in   = S_RESP;
            end
         end
         S_TICK_PASS: begin
            if (r_ff < tot_ff) begin
               pend_shift = 1'b1;
               r_in       = r_ff + 1'b1;
               if (place_ok) begin
                  slot_load_en = 1'b1;
                  cap_in[place_w] = cap_ff[place_w] - head.job_cpu;
                  assigned_in = assigned_ff + 7'd1;
                  cnt_in = cnt_ff - 1'b1;
               end else begin
                  pend_load = 1'b1;
                  load_idx  = tail_idx;
               end
            end else begin
               age_in   = '0;
               state_in = S_AGE_PASS;
            end
         end
         S_AGE_PASS: begin
            slot_rotate  = 1'b1;
            completed_in = completed_ff + done_cnt;
            for (int w = 0; w < WORKER_COUNT; w++) begin
               if (slot_done[w]) begin
                  cap_in[w] = (({1'b0, cap_ff[w]} + {1'b0, slot_q[w][0].cpu}) >
                               8'(FULL_CAP)) ? 7'(FULL_CAP)
                                             : cap_ff[w] + slot_q[w][0].cpu;
               end
            end
            age_in = age_ff + 1'b1;
            if (age_ff == SLOT_IDX_W'(SLOTS_PER_WORKER - 1)) begin
               if (tick_ff != '1) begin
                  tick_in = tick_ff + 32'd1;
               end
               status_in = STAT_TICKED;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status:        status_ff,
                             pending_count: 7'(cnt_ff),
                             busy_workers:  4'(busy_cnt),
                             assigned_now:  assigned_ff,
                             completed_now: completed_ff,
                             elapsed_ticks: tick_ff,
                             total_work:    work_ff,
                             all_done:      (cnt_ff == '0) && (busy_cnt == '0)};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         tick_ff      <= '0;
         work_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sort_mode_ff <= MODE_TIME;
         theta_ff     <= 16'd256;
         wiu_ff       <= 4'd8;
         for (int w = 0; w < WORKER_COUNT; w++) begin
            cap_ff[w] <= 7'(FULL_CAP);
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tick_ff      <= tick_in;
         work_ff      <= work_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int w = 0; w < WORKER_COUNT; w++) begin
            cap_ff[w] <= cap_in[w];
         end
         if (csr_we) begin
            case (csr_idx)
               CSR_SORT_MODE: sort_mode_ff <= csr_wdata[2:0];
               CSR_THETA:     theta_ff     <= csr_wdata;
               CSR_WORKERS:   wiu_ff       <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      tot_ff       <= tot_in;
      r_ff         <= r_in;
      ins_ff       <= ins_in;
      carry_ff     <= carry_in;
      wnew_ff      <= wnew_in;
      whead_ff     <= whead_in;
      assigned_ff  <= assigned_in;
      completed_ff <= completed_in;
      age_ff       <= age_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== rtl/ffjs_checker.sv =====
`timescale 1ns / 1ps
`include "first_fit_job_scheduler_assert.svh"
module ffjs_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ffjs_pkg::rsp_type rsp_data
);
   // a taken request always raises busy in the cycle after it is taken
   `FFJS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // the response shows once the block has gone idle
   `FFJS_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)
   `FFJS_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid)
   // every end of work comes with its response
   `FFJS_ASSERT_NOW(a_done_rsp, $fell(busy), rsp_valid)
   `FFJS_ASSERT_NOW(a_all_done, rsp_valid && rsp_data.all_done,
                    (rsp_data.pending_count == 7'd0) && (rsp_data.busy_workers == 4'd0))
endmodule

bind first_fit_job_scheduler ffjs_checker u_ffjs_checker (.*);
